### design/pedal_plausibility_check_defines.svh
// Assertion macros shared by the pedal plausibility checker.
`ifndef PEDAL_PLAUSIBILITY_CHECK_DEFINES_SVH
`define PEDAL_PLAUSIBILITY_CHECK_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define PPC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pedal plausibility check: assertion failed");

// Next-cycle implication, disabled while reset is high.
`define PPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pedal plausibility check: assertion failed");

`endif

### design/ppc_pkg.sv
// Types, constants and helper functions for the pedal plausibility check.
package ppc_pkg;

   localparam int SampleWidth = 10;
   localparam int CmdWidth    = 11;
   localparam int IndexWidth  = 4;
   localparam int ScaleWidth  = 6;
   localparam int ProdWidth   = CmdWidth + ScaleWidth;

   localparam logic [ScaleWidth-1:0]  ScaleA       = 6'd38;
   localparam logic [ScaleWidth-1:0]  ScaleB       = 6'd42;
   localparam logic [SampleWidth-1:0] SatMax       = 10'd1023;
   localparam logic [CmdWidth-1:0]    InvertBase   = 11'd1024;
   localparam logic [CmdWidth-1:0]    ReleaseLevel = 11'd100;
   localparam logic [CmdWidth-1:0]    AccelLevel   = 11'd50;

   typedef enum logic [IndexWidth-1:0] {
      CSR_ACCEL_A_OFFSET         = 4'd0,
      CSR_ACCEL_B_OFFSET         = 4'd1,
      CSR_BRAKE_OFFSET           = 4'd2,
      CSR_MISMATCH_SET_LEVEL     = 4'd3,
      CSR_MISMATCH_CLEAR_LEVEL   = 4'd4,
      CSR_BRAKE_ON_LEVEL         = 4'd5,
      CSR_BRAKE_OFF_LEVEL        = 4'd6,
      CSR_PEDAL_WITH_BRAKE_LEVEL = 4'd7
   } csr_index_type;

   typedef struct packed {
      logic [SampleWidth-1:0] accel_a_offset;
      logic [SampleWidth-1:0] accel_b_offset;
      logic [SampleWidth-1:0] brake_offset;
      logic [SampleWidth-1:0] mismatch_set_level;
      logic [SampleWidth-1:0] mismatch_clear_level;
      logic [SampleWidth-1:0] brake_on_level;
      logic [SampleWidth-1:0] brake_off_level;
      logic [CmdWidth-1:0]    pedal_with_brake_level;
   } cfg_type;

   localparam cfg_type CfgReset = '{
      accel_a_offset:         10'd125,
      accel_b_offset:         10'd21,
      brake_offset:           10'd510,
      mismatch_set_level:     10'd130,
      mismatch_clear_level:   10'd50,
      brake_on_level:         10'd20,
      brake_off_level:        10'd10,
      pedal_with_brake_level: 11'd400
   };

   // Conditioned readings of one request.
   typedef struct packed {
      logic [SampleWidth-1:0] diff;
      logic [CmdWidth-1:0]    sum;
      logic [SampleWidth-1:0] brake_adj;
   } cond_type;

   typedef struct packed {
      logic mismatch;
      logic overlap;
      logic brake_light;
   } flags_type;

   // Multiply by k/32 (floor) and saturate.
   function automatic logic [SampleWidth-1:0] scale_sat(input logic [CmdWidth-1:0] v,
                                                       input logic [ScaleWidth-1:0] k);
      logic [ProdWidth-1:0] prod;
      logic [ProdWidth-6:0] r;
      prod = ProdWidth'(v) * ProdWidth'(k);
      r    = prod[ProdWidth-1:5];
      return (r > (ProdWidth-5)'(SatMax)) ? SatMax : r[SampleWidth-1:0];
   endfunction

endpackage

### design/ppc_req_if.sv
// Request channel: one sample set per transfer.
interface ppc_req_if;
   logic                             valid;
   logic                             ready;
   logic [ppc_pkg::SampleWidth-1:0]  accel_a_sample;
   logic [ppc_pkg::SampleWidth-1:0]  accel_b_sample;
   logic [ppc_pkg::SampleWidth-1:0]  brake_sample;

   modport source (output valid, accel_a_sample, accel_b_sample, brake_sample,
                   input ready);
   modport sink   (input valid, accel_a_sample, accel_b_sample, brake_sample,
                   output ready);
endinterface

### design/ppc_rsp_if.sv
// Result channel: throttle command and status flags.
interface ppc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ppc_pkg::CmdWidth-1:0]  throttle_command;
   logic                          brake_light;
   logic                          pedal_fault;
   logic                          mismatch_fault;
   logic                          accelerating;

   modport source (output valid, throttle_command, brake_light, pedal_fault,
                   mismatch_fault, accelerating, input ready);
   modport sink   (input valid, throttle_command, brake_light, pedal_fault,
                   mismatch_fault, accelerating, output ready);
endinterface

### design/ppc_csr_if.sv
// Configuration write channel.
interface ppc_csr_if;
   logic                             valid;
   logic                             ready;
   logic [ppc_pkg::IndexWidth-1:0]   index;
   logic [ppc_pkg::CmdWidth-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### design/ppc_csr.sv
// Configuration register file.
module ppc_csr (
   input  logic              clock,
   input  logic              reset,
   ppc_csr_if.sink           csr_ch,
   output ppc_pkg::cfg_type  cfg
);
   ppc_pkg::cfg_type cfg_ff;
   ppc_pkg::cfg_type cfg_in;

   assign csr_ch.ready = 1'b1;
   assign cfg          = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (ppc_pkg::csr_index_type'(csr_ch.index))
            ppc_pkg::CSR_ACCEL_A_OFFSET:
               cfg_in.accel_a_offset = csr_ch.data[ppc_pkg::SampleWidth-1:0];
            ppc_pkg::CSR_ACCEL_B_OFFSET:
               cfg_in.accel_b_offset = csr_ch.data[ppc_pkg::SampleWidth-1:0];
            ppc_pkg::CSR_BRAKE_OFFSET:
               cfg_in.brake_offset = csr_ch.data[ppc_pkg::SampleWidth-1:0];
            ppc_pkg::CSR_MISMATCH_SET_LEVEL:
               cfg_in.mismatch_set_level = csr_ch.data[ppc_pkg::SampleWidth-1:0];
            ppc_pkg::CSR_MISMATCH_CLEAR_LEVEL:
               cfg_in.mismatch_clear_level = csr_ch.data[ppc_pkg::SampleWidth-1:0];
            ppc_pkg::CSR_BRAKE_ON_LEVEL:
               cfg_in.brake_on_level = csr_ch.data[ppc_pkg::SampleWidth-1:0];
            ppc_pkg::CSR_BRAKE_OFF_LEVEL:
               cfg_in.brake_off_level = csr_ch.data[ppc_pkg::SampleWidth-1:0];
            ppc_pkg::CSR_PEDAL_WITH_BRAKE_LEVEL:
               cfg_in.pedal_with_brake_level = csr_ch.data;
            default: ;  // writes beyond the register list are dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= ppc_pkg::CfgReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule

### design/ppc_condition.sv
// Offset removal, scaling, saturation, difference and sum of the readings.
module ppc_condition (
   input  ppc_pkg::cfg_type                  cfg,
   input  logic [ppc_pkg::SampleWidth-1:0]   accel_a_sample,
   input  logic [ppc_pkg::SampleWidth-1:0]   accel_b_sample,
   input  logic [ppc_pkg::SampleWidth-1:0]   brake_sample,
   output ppc_pkg::cond_type                 cond
);
   logic [ppc_pkg::SampleWidth-1:0] a_clamp;
   logic [ppc_pkg::CmdWidth-1:0]    b_inv;
   logic [ppc_pkg::CmdWidth-1:0]    b_clamp;
   logic [ppc_pkg::SampleWidth-1:0] a_scaled;
   logic [ppc_pkg::SampleWidth-1:0] b_scaled;

   always_comb begin
      a_clamp = (accel_a_sample > cfg.accel_a_offset) ?
                accel_a_sample - cfg.accel_a_offset : '0;
      // B is wired inverted
      b_inv   = ppc_pkg::InvertBase - ppc_pkg::CmdWidth'(accel_b_sample);
      b_clamp = (b_inv > ppc_pkg::CmdWidth'(cfg.accel_b_offset)) ?
                b_inv - ppc_pkg::CmdWidth'(cfg.accel_b_offset) : '0;

      a_scaled = ppc_pkg::scale_sat(ppc_pkg::CmdWidth'(a_clamp), ppc_pkg::ScaleA);
      b_scaled = ppc_pkg::scale_sat(b_clamp, ppc_pkg::ScaleB);

      cond.diff      = (a_scaled > b_scaled) ? a_scaled - b_scaled : b_scaled - a_scaled;
      cond.sum       = ppc_pkg::CmdWidth'(a_scaled) + ppc_pkg::CmdWidth'(b_scaled);
      cond.brake_adj = (brake_sample > cfg.brake_offset) ?
                       brake_sample - cfg.brake_offset : '0;
   end
endmodule

### design/ppc_flags.sv
// Mismatch, brake-overlap and brake-light hysteresis flags.
module ppc_flags (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  ppc_pkg::cfg_type   cfg,
   input  ppc_pkg::cond_type  cond,
   output ppc_pkg::flags_type flags_next
);
   ppc_pkg::flags_type flags_ff;
   ppc_pkg::flags_type flags_in;

   always_comb begin
      flags_in = flags_ff;

      if (cond.diff > cfg.mismatch_set_level) begin
         flags_in.mismatch = 1'b1;
      end else if (cond.diff < cfg.mismatch_clear_level) begin
         flags_in.mismatch = 1'b0;
      end

      if (cond.brake_adj > cfg.brake_on_level) begin
         flags_in.brake_light = 1'b1;
         if (cond.sum > cfg.pedal_with_brake_level) begin
            flags_in.overlap = 1'b1;
         end else if (cond.sum < ppc_pkg::ReleaseLevel) begin
            flags_in.overlap = 1'b0;
         end
      end else if (cond.brake_adj < cfg.brake_off_level) begin
         flags_in.brake_light = 1'b0;
         // overlap clears only once the accelerator is released
         if (cond.sum < ppc_pkg::ReleaseLevel) begin
            flags_in.overlap = 1'b0;
         end
      end
   end

   assign flags_next = flags_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else if (advance) begin
         flags_ff <= flags_in;
      end
   end
endmodule

### design/pedal_plausibility_check.sv
// Top level of the accelerator pedal plausibility check.
// One request is taken per clock cycle unless a held result stalls the input register,
// and its result is offered from the result register:
// the sample set is captured in an input register, the conditioning, hysteresis
// and command logic run in one combinational pass, and the result register
// holds the outcome until it is taken. The hysteresis flags advance once per
// request, in request order, so results match request order with any stalling.
// Configuration writes are accepted every cycle and take effect on the next.
module pedal_plausibility_check (
   input  logic       clock,
   input  logic       reset,
   ppc_req_if.sink    req_ch,
   ppc_rsp_if.source  rsp_ch,
   ppc_csr_if.sink    csr_ch
);
   ppc_pkg::cfg_type   cfg;
   ppc_pkg::cond_type  cond;
   ppc_pkg::flags_type flags_next;

   logic                            in_valid_ff;
   logic [ppc_pkg::SampleWidth-1:0] accel_a_ff;
   logic [ppc_pkg::SampleWidth-1:0] accel_b_ff;
   logic [ppc_pkg::SampleWidth-1:0] brake_ff;

   logic                            rsp_valid_ff;
   logic [ppc_pkg::CmdWidth-1:0]    throttle_ff;
   logic                            brake_light_ff;
   logic                            pedal_fault_ff;
   logic                            mismatch_fault_ff;
   logic                            accelerating_ff;

   logic                            advance;
   logic                            fault;
   logic [ppc_pkg::CmdWidth-1:0]    throttle_in;

   ppc_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   ppc_condition u_condition (
      .cfg            (cfg),
      .accel_a_sample (accel_a_ff),
      .accel_b_sample (accel_b_ff),
      .brake_sample   (brake_ff),
      .cond           (cond)
   );

   ppc_flags u_flags (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .cfg        (cfg),
      .cond       (cond),
      .flags_next (flags_next)
   );

   // advance the captured request into the result register when it is free
   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;

   assign fault       = flags_next.mismatch || flags_next.overlap;
   assign throttle_in = fault ? '0 : cond.sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         accel_a_ff <= req_ch.accel_a_sample;
         accel_b_ff <= req_ch.accel_b_sample;
         brake_ff   <= req_ch.brake_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         throttle_ff       <= throttle_in;
         brake_light_ff    <= flags_next.brake_light;
         pedal_fault_ff    <= fault;
         mismatch_fault_ff <= flags_next.mismatch;
         accelerating_ff   <= (throttle_in > ppc_pkg::AccelLevel);
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.throttle_command = throttle_ff;
   assign rsp_ch.brake_light      = brake_light_ff;
   assign rsp_ch.pedal_fault      = pedal_fault_ff;
   assign rsp_ch.mismatch_fault   = mismatch_fault_ff;
   assign rsp_ch.accelerating     = accelerating_ff;
endmodule

### design/ppc_check.sv
// Port-level checker for the pedal plausibility check, bound to the top level.
`include "pedal_plausibility_check_defines.svh"

module ppc_check (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [ppc_pkg::CmdWidth-1:0]  throttle_command,
   input logic                          pedal_fault,
   input logic                          mismatch_fault,
   input logic                          accelerating
);
   `PPC_ASSERT_IMPL(a_fault_zero_cmd, clock, reset, rsp_valid && pedal_fault, throttle_command == '0)
   `PPC_ASSERT_IMPL(a_mismatch_is_fault, clock, reset, rsp_valid && mismatch_fault, pedal_fault)
   `PPC_ASSERT_IMPL(a_accel_flag, clock, reset, rsp_valid, accelerating == (throttle_command > ppc_pkg::AccelLevel))
   `PPC_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(throttle_command))
endmodule

bind pedal_plausibility_check ppc_check u_ppc_check (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .throttle_command (rsp_ch.throttle_command),
   .pedal_fault      (rsp_ch.pedal_fault),
   .mismatch_fault   (rsp_ch.mismatch_fault),
   .accelerating     (rsp_ch.accelerating)
);

### bench/pedal_plausibility_check_tb.sv
// Self-checking testbench for the accelerator pedal plausibility check.
module pedal_plausibility_check_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ppc_pkg::*;

   localparam int RegisterCount = 8;
   localparam int SettleCycles  = 4;

   typedef struct packed {
      logic [CmdWidth-1:0] throttle_command;
      logic                brake_light;
      logic                pedal_fault;
      logic                mismatch_fault;
      logic                accelerating;
   } pedal_result_t;

   typedef enum int {BRAKE_RELEASED, BRAKE_BETWEEN, BRAKE_PRESSED} brake_pos_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ppc_req_if req_ch ();
   ppc_rsp_if rsp_ch ();
   ppc_csr_if csr_ch ();

   pedal_plausibility_check i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #4 clock = ~clock;

   // Bench copy of the block's settings and hysteresis flags
   cfg_type       pedal_settings = CfgReset;
   logic          mismatch_state = 1'b0;
   logic          overlap_state  = 1'b0;
   logic          light_state    = 1'b0;
   pedal_result_t expected_results[$];

   int  error_count    = 0;
   int  sets_sent      = 0;
   int  results_seen   = 0;
   int  register_writes = 0;
   int  settings_used  = 0;
   bit  sender_quiet   = 1'b0;
   bit  receiver_quiet = 1'b0;

   initial begin
      req_ch.valid          = 1'b0;
      req_ch.accel_a_sample = '0;
      req_ch.accel_b_sample = '0;
      req_ch.brake_sample   = '0;
      rsp_ch.ready          = 1'b0;
      csr_ch.valid          = 1'b0;
      csr_ch.index          = '0;
      csr_ch.data           = '0;
   end

   function automatic int draw_wait(input bit quiet);
      return quiet ? 0 : $urandom_range(0, 4);
   endfunction

   function automatic logic [SampleWidth-1:0] to_sample(input int v);
      if (v < 0) return '0;
      if (v > int'(SatMax)) return SatMax;
      return SampleWidth'(v);
   endfunction

   // Multiply by k/32, floor, and saturate to the sample range.
   function automatic int unsigned scale_reading(input int unsigned lin, input int unsigned k);
      int unsigned q;
      q = (lin * k) >> 5;
      return (q > SatMax) ? SatMax : q;
   endfunction

   // Advance the flags by one sample set and queue the result it must give.
   task automatic predict_sample_set(input logic [SampleWidth-1:0] a_s, b_s, br_s);
      int unsigned   a_lin, b_inv, b_lin, br_lin, a_scl, b_scl, gap, total, throttle;
      logic          fault;
      pedal_result_t res;
      a_lin  = (a_s > pedal_settings.accel_a_offset) ? a_s - pedal_settings.accel_a_offset : 0;
      b_inv  = InvertBase - b_s;
      b_lin  = (b_inv > pedal_settings.accel_b_offset) ? b_inv - pedal_settings.accel_b_offset : 0;
      br_lin = (br_s > pedal_settings.brake_offset) ? br_s - pedal_settings.brake_offset : 0;
      a_scl  = scale_reading(a_lin, ScaleA);
      b_scl  = scale_reading(b_lin, ScaleB);
      gap    = (a_scl > b_scl) ? a_scl - b_scl : b_scl - a_scl;
      total  = a_scl + b_scl;

      if (gap > pedal_settings.mismatch_set_level)
         mismatch_state = 1'b1;
      else if (gap < pedal_settings.mismatch_clear_level)
         mismatch_state = 1'b0;

      if (br_lin > pedal_settings.brake_on_level) begin
         light_state = 1'b1;
         if (total > pedal_settings.pedal_with_brake_level)
            overlap_state = 1'b1;
         else if (total < ReleaseLevel)
            overlap_state = 1'b0;
      end else if (br_lin < pedal_settings.brake_off_level) begin
         light_state = 1'b0;
         if (total < ReleaseLevel)
            overlap_state = 1'b0;
      end

      fault    = mismatch_state | overlap_state;
      throttle = fault ? 0 : total;
      res.throttle_command = CmdWidth'(throttle);
      res.brake_light      = light_state;
      res.pedal_fault      = fault;
      res.mismatch_fault   = mismatch_state;
      res.accelerating     = (throttle > AccelLevel);
      expected_results.push_back(res);
   endtask

   task automatic apply_register(input logic [IndexWidth-1:0] idx,
                                 input logic [CmdWidth-1:0] value);
      case (idx)
         CSR_ACCEL_A_OFFSET:         pedal_settings.accel_a_offset = value[SampleWidth-1:0];
         CSR_ACCEL_B_OFFSET:         pedal_settings.accel_b_offset = value[SampleWidth-1:0];
         CSR_BRAKE_OFFSET:           pedal_settings.brake_offset = value[SampleWidth-1:0];
         CSR_MISMATCH_SET_LEVEL:     pedal_settings.mismatch_set_level = value[SampleWidth-1:0];
         CSR_MISMATCH_CLEAR_LEVEL:   pedal_settings.mismatch_clear_level = value[SampleWidth-1:0];
         CSR_BRAKE_ON_LEVEL:         pedal_settings.brake_on_level = value[SampleWidth-1:0];
         CSR_BRAKE_OFF_LEVEL:        pedal_settings.brake_off_level = value[SampleWidth-1:0];
         CSR_PEDAL_WITH_BRAKE_LEVEL: pedal_settings.pedal_with_brake_level = value;
         default: ;
      endcase
   endtask

   task automatic write_register(input logic [IndexWidth-1:0] idx,
                                 input logic [CmdWidth-1:0] value);
      @(negedge clock);
      csr_ch.valid = 1'b1;
      csr_ch.index = idx;
      csr_ch.data  = value;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      apply_register(idx, value);
      register_writes++;
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   // Ten-bit registers get a random top bit, which the block must drop.
   task automatic load_settings(input cfg_type c);
      write_register(CSR_ACCEL_A_OFFSET, {1'($urandom), c.accel_a_offset});
      write_register(CSR_ACCEL_B_OFFSET, {1'($urandom), c.accel_b_offset});
      write_register(CSR_BRAKE_OFFSET, {1'($urandom), c.brake_offset});
      write_register(CSR_MISMATCH_SET_LEVEL, {1'($urandom), c.mismatch_set_level});
      write_register(CSR_MISMATCH_CLEAR_LEVEL, {1'($urandom), c.mismatch_clear_level});
      write_register(CSR_BRAKE_ON_LEVEL, {1'($urandom), c.brake_on_level});
      write_register(CSR_BRAKE_OFF_LEVEL, {1'($urandom), c.brake_off_level});
      write_register(CSR_PEDAL_WITH_BRAKE_LEVEL, c.pedal_with_brake_level);
      settings_used++;
   endtask

   function automatic cfg_type random_settings();
      cfg_type c;
      c.accel_a_offset         = SampleWidth'($urandom_range(0, 300));
      c.accel_b_offset         = SampleWidth'($urandom_range(0, 300));
      c.brake_offset           = SampleWidth'($urandom_range(0, 800));
      c.mismatch_set_level     = SampleWidth'($urandom_range(10, 400));
      c.mismatch_clear_level   = SampleWidth'($urandom_range(0, c.mismatch_set_level));
      c.brake_on_level         = SampleWidth'($urandom_range(1, 200));
      c.brake_off_level        = SampleWidth'($urandom_range(0, c.brake_on_level));
      c.pedal_with_brake_level = CmdWidth'($urandom_range(50, 1200));
      return c;
   endfunction

   task automatic send_sample_set(input logic [SampleWidth-1:0] a_s, b_s, br_s);
      int gap;
      gap = draw_wait(sender_quiet);
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid          = 1'b1;
      req_ch.accel_a_sample = a_s;
      req_ch.accel_b_sample = b_s;
      req_ch.brake_sample   = br_s;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      predict_sample_set(a_s, b_s, br_s);
      sets_sent++;
   endtask

   // Hold off requests until every result is back and the pipeline is empty.
   task automatic wait_for_results();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // Pedal travel as a random walk with matching readings, brake moving between
   // its bands, and a share of raw noise.
   task automatic drive_pedal_walk(input int count, input int noise_pct);
      int         travel, spread, a_v, b_v, br_v;
      brake_pos_t brake_pos;
      travel    = $urandom_range(0, 1023);
      brake_pos = BRAKE_RELEASED;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < noise_pct) begin
            send_sample_set(SampleWidth'($urandom), SampleWidth'($urandom),
                            SampleWidth'($urandom));
         end else begin
            if ($urandom_range(0, 19) == 0)
               travel = $urandom_range(0, 1023);
            else
               travel = travel + int'($urandom_range(0, 80)) - 40;
            travel = (travel < 0) ? 0 : (travel > 1023) ? 1023 : travel;
            if ($urandom_range(0, 9) == 0)
               brake_pos = brake_pos_t'($urandom_range(0, 2));
            spread = ($urandom_range(0, 9) == 0) ? 150 : 4;
            a_v = pedal_settings.accel_a_offset + (travel * 32 + 37) / 38
                  + int'($urandom_range(0, 2 * spread)) - spread;
            b_v = int'(InvertBase) - pedal_settings.accel_b_offset - (travel * 32 + 41) / 42
                  + int'($urandom_range(0, 2 * spread)) - spread;
            case (brake_pos)
               BRAKE_RELEASED: br_v = pedal_settings.brake_offset
                                      + $urandom_range(0, pedal_settings.brake_off_level);
               BRAKE_BETWEEN:  br_v = pedal_settings.brake_offset
                                      + $urandom_range(pedal_settings.brake_off_level,
                                                       pedal_settings.brake_on_level);
               default:        br_v = pedal_settings.brake_offset
                                      + pedal_settings.brake_on_level
                                      + $urandom_range(1, 300);
            endcase
            send_sample_set(to_sample(a_v), to_sample(b_v), to_sample(br_v));
         end
         // Pause now and then until the block has drained
         if ($urandom_range(0, 199) == 0)
            wait_for_results();
      end
   endtask

   task automatic check_result(input pedal_result_t got);
      pedal_result_t want;
      results_seen++;
      if (expected_results.size() == 0) begin
         $error("unexpected result: throttle_command %0d", got.throttle_command);
         error_count++;
         return;
      end
      want = expected_results.pop_front();
      if (got.throttle_command !== want.throttle_command) begin
         $error("throttle_command: expected %0d, got %0d",
                want.throttle_command, got.throttle_command);
         error_count++;
      end
      if (got.brake_light !== want.brake_light) begin
         $error("brake_light: expected %0b, got %0b", want.brake_light, got.brake_light);
         error_count++;
      end
      if (got.pedal_fault !== want.pedal_fault) begin
         $error("pedal_fault: expected %0b, got %0b", want.pedal_fault, got.pedal_fault);
         error_count++;
      end
      if (got.mismatch_fault !== want.mismatch_fault) begin
         $error("mismatch_fault: expected %0b, got %0b",
                want.mismatch_fault, got.mismatch_fault);
         error_count++;
      end
      if (got.accelerating !== want.accelerating) begin
         $error("accelerating: expected %0b, got %0b", want.accelerating, got.accelerating);
         error_count++;
      end
   endtask

   initial begin : result_checker
      pedal_result_t got;
      int            stall;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         stall = draw_wait(receiver_quiet);
         if (stall > 0) begin
            rsp_ch.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
         got.throttle_command = rsp_ch.throttle_command;
         got.brake_light      = rsp_ch.brake_light;
         got.pedal_fault      = rsp_ch.pedal_fault;
         got.mismatch_fault   = rsp_ch.mismatch_fault;
         got.accelerating     = rsp_ch.accelerating;
         check_result(got);
      end
   end

   // Reset settings: extremes, accelerating threshold, offset clamping, saturation,
   // both hysteresis loops through set, hold and clear.
   task automatic test_directed_defaults();
      send_sample_set(10'd0, 10'd0, 10'd0);          // B saturates, mismatch sets
      send_sample_set(10'd1023, 10'd1023, 10'd1023); // A saturates, B clamps, brake on
      send_sample_set(10'd1023, 10'd0, 10'd0);       // both saturate, mismatch clears
      send_sample_set(10'd167, 10'd1002, 10'd0);     // command of exactly fifty
      send_sample_set(10'd168, 10'd1023, 10'd0);     // command just above fifty
      send_sample_set(10'd100, 10'd1023, 10'd0);     // A below its offset
      send_sample_set(10'd168, 10'd1023, 10'd530);   // brake at on level: hold
      send_sample_set(10'd168, 10'd1023, 10'd531);   // brake just above on level
      send_sample_set(10'd168, 10'd1023, 10'd520);   // brake at off level: hold
      send_sample_set(10'd168, 10'd1023, 10'd519);   // brake just below off level
      send_sample_set(10'd1023, 10'd0, 10'd600);     // pedal with brake: overlap
      send_sample_set(10'd400, 10'd1023, 10'd600);   // braking, mid sum: hold overlap
      send_sample_set(10'd1023, 10'd0, 10'd0);       // brake off, pedal held: hold
      send_sample_set(10'd0, 10'd1023, 10'd0);       // pedal released: overlap clears
      send_sample_set(10'd200, 10'd1023, 10'd600);   // braking, small sum: no overlap
      send_sample_set(10'd300, 10'd1023, 10'd0);     // large gap: mismatch sets
      send_sample_set(10'd300, 10'd913, 10'd0);      // gap between levels: hold
      send_sample_set(10'd300, 10'd845, 10'd0);      // readings agree: mismatch clears
      send_sample_set(10'h2AA, 10'h155, 10'h2AA);
      send_sample_set(10'h155, 10'h2AA, 10'h155);
      wait_for_results();
   endtask

   // A write to an index outside the map must leave every setting alone.
   task automatic test_unused_index();
      write_register(IndexWidth'(RegisterCount + $urandom_range(0, (1 << IndexWidth) - 1
                                                                 - RegisterCount)),
                     CmdWidth'($urandom));
      drive_pedal_walk(20, 10);
      wait_for_results();
   endtask

   task automatic test_extreme_settings();
      cfg_type c;
      c = '0;
      load_settings(c);
      drive_pedal_walk(30, 30);
      wait_for_results();
      c = '1;
      load_settings(c);
      drive_pedal_walk(30, 30);
      wait_for_results();
      // Clear and off levels at or above their set and on levels
      c = random_settings();
      c.mismatch_clear_level = SampleWidth'($urandom_range(c.mismatch_set_level, 1023));
      c.brake_off_level      = SampleWidth'($urandom_range(c.brake_on_level, 1023));
      load_settings(c);
      drive_pedal_walk(60, 20);
      wait_for_results();
   endtask

   task automatic test_random_phases();
      for (int phase = 0; phase < 8; phase++) begin
         sender_quiet   = ($urandom_range(0, 3) == 0);
         receiver_quiet = ($urandom_range(0, 3) == 0);
         load_settings((phase == 0) ? CfgReset : random_settings());
         drive_pedal_walk(180, 15);
         wait_for_results();
      end
      sender_quiet   = 1'b0;
      receiver_quiet = 1'b0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed_defaults();
      test_unused_index();
      test_extreme_settings();
      test_random_phases();
      wait_for_results();
      repeat (2 * SettleCycles) @(posedge clock);
      if (expected_results.size() != 0) begin
         $error("%0d results never arrived", expected_results.size());
         error_count++;
      end
      $display("Sent %0d sample sets under %0d register settings (%0d register writes),",
               sets_sent, settings_used, register_writes);
      $display("checked %0d results with random stalls on both channels.", results_seen);
      if (error_count == 0)
         $display("pedal_plausibility_check regression: pass");
      else
         $display("pedal_plausibility_check regression: fail");
      $finish;
   end

   initial begin
      #3ms;
      $display("pedal_plausibility_check regression: fail");
      $finish;
   end

endmodule
